// ===== sv/mfap_pkg.sv =====
package mfap_pkg;

  localparam int MaxNodes  = 256;
  localparam int NodeW     = 8;
  localparam int EdgePairs = 1024;               // two slots per loaded edge
  localparam int PairW     = 10;                 // index into the edge pairs
  localparam int PairCntW  = 11;                 // 0..EdgePairs
  localparam int PosW      = 12;                 // slot scan position, 0..2*EdgePairs
  localparam int CapW      = 32;
  localparam int LimW      = 33;
  localparam int SumW      = 42;
  localparam int DepthW    = 9;                  // 0..MaxNodes
  localparam int NodeCntW  = 9;

  localparam logic [LimW-1:0] BigLim = {LimW{1'b1}};

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_RANGE = 2'd2,
    ERR_SAME  = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    CFG_NODE_COUNT = 2'd0,
    CFG_SOURCE     = 2'd1,
    CFG_SINK       = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic             has_edge;
    logic [NodeW-1:0] from_node;
    logic [NodeW-1:0] to_node;
    logic [CapW-1:0]  capacity;
    logic             last;
  } in_beat_t;

  typedef struct packed {
    logic [SumW-1:0] total_flow;
    logic [1:0]      error_code;
  } out_beat_t;

  // one stored edge: slot 2k is from->to with capacity, slot 2k+1 its reverse
  typedef struct packed {
    logic [NodeW-1:0] from_node;
    logic [NodeW-1:0] to_node;
    logic [CapW-1:0]  capacity;
  } edge_ent_t;

  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [PosW-1:0]  pos;
    logic [LimW-1:0]  lim;
  } stk_ent_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_CLR,
    ST_START,
    ST_EXAM,
    ST_EVAL,
    ST_POP,
    ST_POPLD,
    ST_AUG_RS,
    ST_AUG_RF,
    ST_AUG_WR,
    ST_ADD,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic chk;
    logic clr;
    logic start;
    logic eval;
    logic pop;
    logic popld;
    logic aug_rs;
    logic aug_rf;
    logic aug_wr;
    logic add;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic       in_last;
    logic [1:0] err;
    logic       pair_zero;
    logic       clr_last;
    logic       at_sink;
    logic       pos_end;
    logic       push_ok;
    logic       depth_one;
    logic       aug_last;
    logic       out_busy;
  } stat_t;

endpackage

// ===== sv/mfap_ram.sv =====
module mfap_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mfap_ctrl.sv =====
module mfap_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  mfap_pkg::stat_t stat_i,
  output logic           in_stall_o,
  output mfap_pkg::cmd_t cmd_o
);

  mfap_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mfap_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      mfap_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (stat_i.in_last) state_d = mfap_pkg::ST_CHK;
        end
      end
      mfap_pkg::ST_CHK: begin
        cmd_o.chk = 1'b1;
        if (stat_i.err != mfap_pkg::ERR_OK) state_d = mfap_pkg::ST_FIN;
        else if (stat_i.pair_zero) state_d = mfap_pkg::ST_START;
        else state_d = mfap_pkg::ST_CLR;
      end
      mfap_pkg::ST_CLR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) state_d = mfap_pkg::ST_START;
      end
      mfap_pkg::ST_START: begin
        cmd_o.start = 1'b1;
        state_d = mfap_pkg::ST_EXAM;
      end
      mfap_pkg::ST_EXAM: begin
        // edge read for the scan position is in flight here
        if (stat_i.at_sink) state_d = mfap_pkg::ST_AUG_RS;
        else if (stat_i.pos_end) state_d = mfap_pkg::ST_POP;
        else state_d = mfap_pkg::ST_EVAL;
      end
      mfap_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d = mfap_pkg::ST_EXAM;
      end
      mfap_pkg::ST_POP: begin
        cmd_o.pop = 1'b1;
        if (stat_i.depth_one) state_d = mfap_pkg::ST_FIN;
        else state_d = mfap_pkg::ST_POPLD;
      end
      mfap_pkg::ST_POPLD: begin
        cmd_o.popld = 1'b1;
        state_d = mfap_pkg::ST_EXAM;
      end
      mfap_pkg::ST_AUG_RS: begin
        cmd_o.aug_rs = 1'b1;
        state_d = mfap_pkg::ST_AUG_RF;
      end
      mfap_pkg::ST_AUG_RF: begin
        cmd_o.aug_rf = 1'b1;
        state_d = mfap_pkg::ST_AUG_WR;
      end
      mfap_pkg::ST_AUG_WR: begin
        cmd_o.aug_wr = 1'b1;
        if (stat_i.aug_last) state_d = mfap_pkg::ST_ADD;
        else state_d = mfap_pkg::ST_AUG_RS;
      end
      mfap_pkg::ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d = mfap_pkg::ST_START;
      end
      mfap_pkg::ST_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.fin = 1'b1;
          state_d = mfap_pkg::ST_IDLE;
        end
      end
      default: state_d = mfap_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== sv/mfap_dp.sv =====
module mfap_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [8:0]          cfg_data_i,
  input  mfap_pkg::in_beat_t  in_data_i,
  input  logic                out_stall_i,
  input  mfap_pkg::cmd_t      cmd_i,
  output mfap_pkg::stat_t     stat_o,
  output logic                out_valid_o,
  output mfap_pkg::out_beat_t out_data_o
);

  localparam int NW = mfap_pkg::NodeW;
  localparam int PW = mfap_pkg::PairW;

  logic [mfap_pkg::NodeCntW-1:0] node_count_q;
  logic [NW-1:0]                 src_q, snk_q;
  logic [mfap_pkg::PairCntW-1:0] pair_cnt_q;
  logic [1:0]                    load_err_q;
  logic [mfap_pkg::SumW-1:0]     sum_q;
  logic [mfap_pkg::DepthW-1:0]   depth_q;
  logic [NW-1:0]                 cur_node_q;
  logic [mfap_pkg::PosW-1:0]     cur_pos_q;
  logic [mfap_pkg::LimW-1:0]     cur_lim_q;
  logic [mfap_pkg::MaxNodes-1:0] visited_q;
  logic [PW-1:0]                 clr_idx_q;
  logic [NW-1:0]                 aug_i_q;
  logic [PW-1:0]                 aug_addr_q;
  logic                          aug_lsb_q;
  logic                          out_valid_q;
  mfap_pkg::out_beat_t           out_q;

  mfap_pkg::edge_ent_t edge_rd;
  mfap_pkg::stk_ent_t  stk_rd, stk_wr;
  logic [mfap_pkg::CapW-1:0] flow_rd, flow_wr, res, aug;
  logic [NW-1:0]             tail, tgt;
  logic [mfap_pkg::LimW-1:0] new_lim;
  logic [mfap_pkg::PosW-1:0] aug_edge;
  logic [mfap_pkg::DepthW-1:0] dm1, dm2;
  logic [mfap_pkg::PairCntW-1:0] pair_m1;
  logic                      range_bad, edge_bad, pair_full, edge_we;
  logic [1:0]                err;

  // node is out of range when it is not below min(node_count, MaxNodes)
  function automatic logic node_bad(input logic [NW-1:0] n,
                                    input logic [mfap_pkg::NodeCntW-1:0] cnt);
    node_bad = {1'b0, n} >= cnt;
  endfunction

  assign dm1     = depth_q - mfap_pkg::DepthW'(1);
  assign dm2     = depth_q - mfap_pkg::DepthW'(2);
  assign pair_m1 = pair_cnt_q - mfap_pkg::PairCntW'(1);
  assign aug     = cur_lim_q[mfap_pkg::CapW-1:0];

  assign pair_full = pair_cnt_q == mfap_pkg::PairCntW'(mfap_pkg::EdgePairs);
  assign edge_bad  = node_bad(in_data_i.from_node, node_count_q)
                   || node_bad(in_data_i.to_node, node_count_q);
  assign edge_we   = cmd_i.load && in_data_i.has_edge && !pair_full && !edge_bad;

  assign range_bad = node_bad(src_q, node_count_q) || node_bad(snk_q, node_count_q);
  always_comb begin
    if (load_err_q != mfap_pkg::ERR_OK) err = load_err_q;
    else if (range_bad) err = mfap_pkg::ERR_RANGE;
    else if (src_q == snk_q) err = mfap_pkg::ERR_SAME;
    else err = mfap_pkg::ERR_OK;
  end

  // odd slots are the reverse partners: swapped ends, residual equals flow
  always_comb begin
    if (cur_pos_q[0]) begin
      tail = edge_rd.to_node;
      tgt  = edge_rd.from_node;
      res  = flow_rd;
    end else begin
      tail = edge_rd.from_node;
      tgt  = edge_rd.to_node;
      res  = edge_rd.capacity - flow_rd;
    end
    new_lim = (cur_lim_q < {1'b0, res}) ? cur_lim_q : {1'b0, res};
  end

  assign aug_edge = stk_rd.pos - mfap_pkg::PosW'(1);
  assign flow_wr  = cmd_i.clr ? '0 : (aug_lsb_q ? flow_rd - aug : flow_rd + aug);

  assign stk_wr.node = cur_node_q;
  assign stk_wr.pos  = cur_pos_q + mfap_pkg::PosW'(1);
  assign stk_wr.lim  = cur_lim_q;

  assign stat_o.in_last   = in_data_i.last;
  assign stat_o.err       = err;
  assign stat_o.pair_zero = pair_cnt_q == '0;
  assign stat_o.clr_last  = clr_idx_q == pair_m1[PW-1:0];
  assign stat_o.at_sink   = cur_node_q == snk_q;
  assign stat_o.pos_end   = cur_pos_q >= {pair_cnt_q, 1'b0};
  assign stat_o.push_ok   = tail == cur_node_q && !visited_q[tgt] && res != '0
                          && depth_q != mfap_pkg::DepthW'(mfap_pkg::MaxNodes);
  assign stat_o.depth_one = depth_q == mfap_pkg::DepthW'(1);
  assign stat_o.aug_last  = {1'b0, aug_i_q} == dm2;
  assign stat_o.out_busy  = out_valid_q;

  mfap_ram #(.Width($bits(mfap_pkg::edge_ent_t)), .Depth(mfap_pkg::EdgePairs)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (pair_cnt_q[PW-1:0]),
    .wdata_i ({in_data_i.from_node, in_data_i.to_node, in_data_i.capacity}),
    .raddr_i (cur_pos_q[PW:1]),
    .rdata_o (edge_rd)
  );

  mfap_ram #(.Width(mfap_pkg::CapW), .Depth(mfap_pkg::EdgePairs)) u_flow_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr || cmd_i.aug_wr),
    .waddr_i (cmd_i.clr ? clr_idx_q : aug_addr_q),
    .wdata_i (flow_wr),
    .raddr_i (cmd_i.aug_rf ? aug_edge[PW:1] : cur_pos_q[PW:1]),
    .rdata_o (flow_rd)
  );

  mfap_ram #(.Width($bits(mfap_pkg::stk_ent_t)), .Depth(mfap_pkg::MaxNodes)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.eval && stat_o.push_ok),
    .waddr_i (dm1[NW-1:0]),
    .wdata_i (stk_wr),
    .raddr_i (cmd_i.aug_rs ? aug_i_q : dm2[NW-1:0]),
    .rdata_o (stk_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= mfap_pkg::NodeCntW'(mfap_pkg::MaxNodes);
      src_q        <= '0;
      snk_q        <= NW'(1);
      pair_cnt_q   <= '0;
      load_err_q   <= mfap_pkg::ERR_OK;
      sum_q        <= '0;
      depth_q      <= '0;
      out_valid_q  <= 1'b0;
      visited_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mfap_pkg::CFG_NODE_COUNT: node_count_q <= cfg_data_i;
          mfap_pkg::CFG_SOURCE:     src_q <= cfg_data_i[NW-1:0];
          mfap_pkg::CFG_SINK:       snk_q <= cfg_data_i[NW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load && in_data_i.has_edge) begin
        if (pair_full) begin
          if (load_err_q == mfap_pkg::ERR_OK) load_err_q <= mfap_pkg::ERR_FULL;
        end else if (edge_bad) begin
          if (load_err_q == mfap_pkg::ERR_OK) load_err_q <= mfap_pkg::ERR_RANGE;
        end else begin
          pair_cnt_q <= pair_cnt_q + mfap_pkg::PairCntW'(1);
        end
      end
      if (cmd_i.chk) sum_q <= '0;
      if (cmd_i.add) sum_q <= sum_q + mfap_pkg::SumW'(aug);
      if (cmd_i.start) begin
        // only the source is marked at the start of a search
        visited_q <= {{(mfap_pkg::MaxNodes-1){1'b0}}, 1'b1} << src_q;
        depth_q   <= mfap_pkg::DepthW'(1);
      end
      if (cmd_i.eval && stat_o.push_ok) begin
        depth_q <= depth_q + mfap_pkg::DepthW'(1);
        if (tgt != snk_q) visited_q[tgt] <= 1'b1;
      end
      if (cmd_i.pop) depth_q <= dm1;
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
        pair_cnt_q  <= '0;
        load_err_q  <= mfap_pkg::ERR_OK;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // search and result registers: payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.chk) clr_idx_q <= '0;
    if (cmd_i.clr) clr_idx_q <= clr_idx_q + PW'(1);
    if (cmd_i.start) begin
      cur_node_q <= src_q;
      cur_pos_q  <= '0;
      cur_lim_q  <= mfap_pkg::BigLim;
      aug_i_q    <= '0;
    end
    if (cmd_i.eval) begin
      if (stat_o.push_ok) begin
        cur_node_q <= tgt;
        cur_pos_q  <= '0;
        cur_lim_q  <= new_lim;
      end else begin
        cur_pos_q <= cur_pos_q + mfap_pkg::PosW'(1);
      end
    end
    if (cmd_i.popld) begin
      cur_node_q <= stk_rd.node;
      cur_pos_q  <= stk_rd.pos;
      cur_lim_q  <= stk_rd.lim;
    end
    if (cmd_i.aug_rf) begin
      aug_addr_q <= aug_edge[PW:1];
      aug_lsb_q  <= aug_edge[0];
    end
    if (cmd_i.aug_wr) aug_i_q <= aug_i_q + NW'(1);
    if (cmd_i.fin) begin
      out_q.error_code <= err;
      out_q.total_flow <= (err == mfap_pkg::ERR_OK) ? sum_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_pair_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_cnt_q <= mfap_pkg::PairCntW'(mfap_pkg::EdgePairs))
    else $error("edge pair count beyond store");
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= mfap_pkg::DepthW'(mfap_pkg::MaxNodes))
    else $error("search stack overrun");
  a_lim_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.eval && stat_o.push_ok |=> cur_lim_q != '0)
    else $error("pushed a path with no residual");
  a_fin_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin |=> pair_cnt_q == '0 && out_valid_q)
    else $error("result not posted or edges not dropped");

endmodule

// ===== sv/max_flow_augmenting_path_top.sv =====
// input: an edge beat is taken while the block is idle; the beat marked last starts the flow run
// run: a check, a flow clear per loaded edge, then per search a start, an exam and eval
// per edge slot scanned (each pushed node scans from slot 0), a pop and reload per
// backtrack, stack and flow reads and a flow write per path edge, then an augment add
// throughput: edge beats at one per cycle; input stalls for the whole flow run
// reset: async active low; config to 256 nodes, source 0, sink 1; no edges loaded
module max_flow_augmenting_path_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [8:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mfap_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mfap_pkg::out_beat_t out_data_o
);

  mfap_pkg::cmd_t  cmd;
  mfap_pkg::stat_t stat;

  mfap_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  mfap_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/tb_max_flow_augmenting_path_top.sv =====
module tb_max_flow_augmenting_path_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SlotCnt   = 2 * mfap_pkg::EdgePairs;
  localparam int IdleLimit = 10000000;
  localparam int RandItems = 250;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [1:0]          cfg_idx;
  logic [8:0]          cfg_data;
  logic                in_valid;
  logic                in_stall;
  mfap_pkg::in_beat_t  in_data;
  logic                out_valid;
  logic                out_stall;
  mfap_pkg::out_beat_t out_data;

  max_flow_augmenting_path_top u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // network predictor state
  int             net_nodes, net_src, net_snk;
  int             slot_cnt;
  mfap_pkg::err_e pend_err;
  int             slot_head [SlotCnt];
  longint         slot_cap  [SlotCnt];
  longint         slot_flow [SlotCnt];
  bit             seen_node [mfap_pkg::MaxNodes];

  mfap_pkg::out_beat_t flow_q[$];
  int          mismatches, beats_in, beats_out;
  int          err_seen [4];
  bit          burst_mode;

  function automatic longint push_path(int u, int t, longint lim);
    longint res, got;
    if (u == t) begin
      return lim;
    end
    seen_node[u] = 1'b1;
    for (int id = 0; id < slot_cnt; id++) begin
      if (slot_head[id ^ 1] != u || seen_node[slot_head[id]]) continue;
      res = slot_cap[id] - slot_flow[id];
      if (res <= 0) continue;
      got = push_path(slot_head[id], t, (lim < res) ? lim : res);
      if (got > 0) begin
        slot_flow[id]     += got;
        slot_flow[id ^ 1] -= got;
        return got;
      end
    end
    return 0;
  endfunction

  function automatic mfap_pkg::out_beat_t solve_flow();
    mfap_pkg::out_beat_t r;
    int          lim;
    longint      aug;
    logic [63:0] total;
    lim   = (net_nodes < mfap_pkg::MaxNodes) ? net_nodes : mfap_pkg::MaxNodes;
    total = '0;
    r     = '0;
    if (pend_err != mfap_pkg::ERR_OK) begin
      r.error_code = pend_err;
    end else if (net_src >= lim || net_snk >= lim) begin
      r.error_code = mfap_pkg::ERR_RANGE;
    end else if (net_src == net_snk) begin
      r.error_code = mfap_pkg::ERR_SAME;
    end else begin
      for (int i = 0; i < slot_cnt; i++) slot_flow[i] = 0;
      do begin
        for (int n = 0; n < mfap_pkg::MaxNodes; n++) seen_node[n] = 1'b0;
        aug = push_path(net_src, net_snk, 64'h7fff_ffff_ffff_ffff);
        total += aug;
      end while (aug != 0);
      r.total_flow = total[mfap_pkg::SumW-1:0];
      r.error_code = mfap_pkg::ERR_OK;
    end
    return r;
  endfunction

  // returns 1 when the beat produces a result
  function automatic bit take_beat(mfap_pkg::in_beat_t b, output mfap_pkg::out_beat_t r);
    int lim;
    lim = (net_nodes < mfap_pkg::MaxNodes) ? net_nodes : mfap_pkg::MaxNodes;
    r   = '0;
    if (b.has_edge) begin
      if (slot_cnt + 2 > SlotCnt) begin
        if (pend_err == mfap_pkg::ERR_OK) pend_err = mfap_pkg::ERR_FULL;
      end else if (b.from_node >= lim || b.to_node >= lim) begin
        if (pend_err == mfap_pkg::ERR_OK) pend_err = mfap_pkg::ERR_RANGE;
      end else begin
        slot_head[slot_cnt]     = b.to_node;
        slot_cap[slot_cnt]      = b.capacity;
        slot_head[slot_cnt + 1] = b.from_node;
        slot_cap[slot_cnt + 1]  = 0;
        slot_cnt += 2;
      end
    end
    if (!b.last) return 1'b0;
    r        = solve_flow();
    slot_cnt = 0;
    pend_err = mfap_pkg::ERR_OK;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_beat(mfap_pkg::in_beat_t b, bit typed, mfap_pkg::out_beat_t typed_exp);
    int                  gap;
    mfap_pkg::out_beat_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    beats_in++;
    if (take_beat(b, r)) flow_q.insert(flow_q.size(), typed ? typed_exp : r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (flow_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_cfg(int nodes, int src, int snk);
    drain();
    cfg_we <= 1'b1; cfg_idx <= mfap_pkg::CFG_NODE_COUNT; cfg_data <= nodes[8:0];
    @(posedge clk);
    cfg_idx <= mfap_pkg::CFG_SOURCE; cfg_data <= src[8:0];
    @(posedge clk);
    cfg_idx <= mfap_pkg::CFG_SINK; cfg_data <= snk[8:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    net_nodes = nodes;
    net_src   = src;
    net_snk   = snk;
  endtask

  function automatic mfap_pkg::in_beat_t mk(bit he, int f, int t, logic [31:0] c, bit l);
    mfap_pkg::in_beat_t b;
    b.has_edge  = he;
    b.from_node = f[7:0];
    b.to_node   = t[7:0];
    b.capacity  = c;
    b.last      = l;
    return b;
  endfunction

  // directed table
  typedef struct {
    bit                  is_cfg;
    int                  c_nodes, c_src, c_snk;
    mfap_pkg::in_beat_t  beat;
    bit                  typed;
    mfap_pkg::out_beat_t want;
  } row_t;
  row_t rows[$];

  function automatic void row_cfg(int n, int s, int t);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1; r.c_nodes = n; r.c_src = s; r.c_snk = t;
    rows.insert(rows.size(), r);
  endfunction

  function automatic void row_beat(mfap_pkg::in_beat_t b);
    row_t r;
    r = '{default: '0};
    r.beat = b;
    rows.insert(rows.size(), r);
  endfunction

  function automatic void row_want(logic [mfap_pkg::SumW-1:0] f, mfap_pkg::err_e e);
    rows[rows.size() - 1].typed           = 1'b1;
    rows[rows.size() - 1].want.total_flow = f;
    rows[rows.size() - 1].want.error_code = e;
  endfunction

  // result side: check, random stall, one long hold-off
  int hold_cnt;
  bit hold_done;
  bit hold_go;
  always @(posedge clk) begin
    mfap_pkg::out_beat_t e;
    if (rst_n && out_valid && !out_stall) begin
      beats_out++;
      err_seen[out_data.error_code]++;
      if (flow_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat flow=%0d err=%0d",
                                       out_data.total_flow, out_data.error_code);
      end else begin
        e = flow_q.pop_front();
        if (e.total_flow !== out_data.total_flow || e.error_code !== out_data.error_code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected flow=%0d err=%0d, got flow=%0d err=%0d",
                     beats_out, e.total_flow, e.error_code,
                     out_data.total_flow, out_data.error_code);
        end
      end
    end
    if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && hold_go) begin
      hold_done <= 1'b1;
      hold_cnt  <= 400;
      out_stall <= 1'b1;
    end else if (burst_mode) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 30);
    end
  end

  int idle_cycles;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no progress for %0d cycles", IdleLimit);
      $display("max_flow_augmenting_path_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // huge capacities only on edges leaving the source keep the path count small
  function automatic logic [31:0] rand_cap(bit big);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 15);
    if (!big || r < 75) return $urandom_range(0, 255);
    if (r < 85) return 32'hffff_ffff;
    return $urandom();
  endfunction

  initial begin
    int                  nodes, src, snk, n_items, k, f, t;
    mfap_pkg::out_beat_t none, full_want;
    none = '0;
    full_want = '0;
    full_want.error_code = mfap_pkg::ERR_FULL;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_idx = mfap_pkg::CFG_NODE_COUNT; cfg_data = '0;
    in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    hold_cnt = 0; hold_done = 1'b0; hold_go = 1'b0; idle_cycles = 0; burst_mode = 1'b0;
    net_nodes = 256; net_src = 0; net_snk = 1; slot_cnt = 0; pend_err = mfap_pkg::ERR_OK;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    row_beat(mk(0, 0, 0, 0, 1));                        row_want(0, mfap_pkg::ERR_OK);
    row_beat(mk(1, 0, 1, 32'hffff_ffff, 0));
    row_beat(mk(1, 0, 1, 32'hffff_ffff, 1));
    row_want(42'h1_ffff_fffe, mfap_pkg::ERR_OK);
    row_beat(mk(1, 0, 2, 5, 0));
    row_beat(mk(1, 2, 1, 3, 0));
    row_beat(mk(1, 0, 1, 0, 0));
    row_beat(mk(0, 255, 255, 32'hffff_ffff, 1));
    row_beat(mk(1, 255, 0, 7, 1));                      row_want(0, mfap_pkg::ERR_OK);
    row_cfg(4, 0, 3);
    row_beat(mk(1, 0, 9, 1, 1));                        row_want(0, mfap_pkg::ERR_RANGE);
    row_cfg(4, 3, 3);
    row_beat(mk(0, 0, 0, 0, 1));                        row_want(0, mfap_pkg::ERR_SAME);
    row_cfg(1, 0, 0);
    row_beat(mk(0, 0, 0, 0, 1));                        row_want(0, mfap_pkg::ERR_SAME);
    row_cfg(2, 1, 0);
    row_beat(mk(1, 1, 1, 4, 0));
    row_beat(mk(1, 1, 0, 9, 1));                        row_want(9, mfap_pkg::ERR_OK);
    row_cfg(511, 255, 254);
    row_beat(mk(1, 255, 254, 1, 0));
    row_beat(mk(1, 254, 255, 2, 1));                    row_want(1, mfap_pkg::ERR_OK);
    row_cfg(5, 6, 0);
    row_beat(mk(1, 0, 1, 3, 1));                        row_want(0, mfap_pkg::ERR_RANGE);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) set_cfg(rows[i].c_nodes, rows[i].c_src, rows[i].c_snk);
      else send_beat(rows[i].beat, rows[i].typed, rows[i].want);
    end

    // receiver holds off while small networks keep coming, so the input stalls
    set_cfg(8, 0, 3);
    hold_go = 1'b1;
    for (int i = 0; i < 12; i++)
      send_beat(mk(1, i[0] ? 1 : 0, i[0] ? 3 : 1, 32'(i + 2), i[0]), 1'b0, none);

    // edge store overflow
    set_cfg(256, 0, 1);
    burst_mode = 1'b1;
    for (int i = 0; i <= mfap_pkg::EdgePairs; i++)
      send_beat(mk(1, i % 200, (i * 7 + 1) % 256, rand_cap(1'b1), i == mfap_pkg::EdgePairs),
                i == mfap_pkg::EdgePairs, (i == mfap_pkg::EdgePairs) ? full_want : none);
    burst_mode = 1'b0;

    // random networks
    k = 0;
    while (k < RandItems) begin
      case ($urandom_range(0, 9))
        0:       nodes = $urandom_range(256, 511);
        1:       nodes = $urandom_range(1, 255);
        default: nodes = $urandom_range(2, 8);
      endcase
      src = $urandom_range(0, (nodes > 255) ? 255 : nodes - 1);
      snk = $urandom_range(0, (nodes > 255) ? 255 : nodes - 1);
      if ($urandom_range(0, 9) == 0) src = $urandom_range(0, 255);
      if (src == snk && $urandom_range(0, 3) != 0)
        snk = (src + 1) % ((nodes > 255) ? 256 : nodes);
      set_cfg(nodes, src, snk);
      burst_mode = ($urandom_range(0, 4) == 0);
      n_items = $urandom_range(1, 12);
      for (int i = 0; i < n_items; i++) begin
        if (nodes > 8 && $urandom_range(0, 1)) begin
          f = $urandom_range(0, 255);
          t = $urandom_range(0, 255);
        end else begin
          f = $urandom_range(0, (nodes < 9) ? nodes - 1 : 7);
          t = $urandom_range(0, (nodes < 9) ? nodes - 1 : 7);
          if ($urandom_range(0, 19) == 0) t = $urandom_range(0, 255);
        end
        send_beat(mk($urandom_range(0, 9) != 0, f, t, rand_cap(f == src), i == n_items - 1),
                  1'b0, none);
        k++;
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("sent %0d edge beats, checked %0d flow results (ok %0d, full %0d, range %0d, same %0d)",
             beats_in, beats_out, err_seen[0], err_seen[1], err_seen[2], err_seen[3]);
    if (mismatches == 0 && flow_q.size() == 0) begin
      $display("max_flow_augmenting_path_top: match");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, flow_q.size());
      $display("max_flow_augmenting_path_top: mismatch");
    end
    $finish;
  end

endmodule
